@@ design/sobm_pkg.sv @@
`timescale 1ns / 1ps

package sobm_pkg;

    localparam int LEVELS_DEF = 16;
    localparam int PW         = 32;
    localparam int SW         = 32;
    localparam int IDW        = 64;
    localparam int ACCW       = 37;
    localparam int DEPW       = 5;
    localparam int TKW        = 16;
    localparam int IMBW       = 16;
    localparam int MIDW       = 33;
    localparam int OUT_LW     = 5;
    localparam int CFG_IW     = 8;
    localparam int CFG_DW     = 16;

    localparam logic [TKW-1:0]    STALE_RST = 16'd5;
    localparam logic [DEPW-1:0]   DEPTH_RST = 5'd5;
    localparam logic [CFG_IW-1:0] CFG_STALE = 8'd0;
    localparam logic [CFG_IW-1:0] CFG_DEPTH = 8'd1;

    typedef enum logic [2:0] {
        OP_RESET, OP_SNAP_BEGIN, OP_SNAP_LEVEL, OP_SNAP_END,
        OP_UPD_BEGIN, OP_UPD_LEVEL, OP_UPD_END, OP_TICK
    } op_t;

    typedef enum logic [1:0] {MODE_IDLE, MODE_SNAP, MODE_UPD, MODE_SKIP} mode_t;

    typedef enum logic [1:0] {CMD_NONE, CMD_CLEAR, CMD_UPSERT, CMD_ERASE} cmd_kind_t;

    typedef enum logic [2:0] {ST_IDLE, ST_APPLY, ST_SUM, ST_DIV, ST_DONE} state_t;

    typedef struct packed {
        cmd_kind_t       kind;
        logic [PW-1:0]   price;
        logic [SW-1:0]   size;
        logic [DEPW-1:0] depth;
    } side_cmd_t;

    typedef struct packed {
        cmd_kind_t       kind;
        logic [PW-1:0]   price;
        logic [SW-1:0]   size;
        logic [DEPW-1:0] depth;
        logic            any_eq;
    } cell_cmd_t;

endpackage

@@ design/sobm_cell.sv @@
`timescale 1ns / 1ps

module sobm_cell #(
    parameter int IDX    = 0,
    parameter bit IS_ASK = 1'b0,
    parameter int CNTW   = 5
) (
    input  logic                      clk,
    input  sobm_pkg::cell_cmd_t       cmd,
    input  logic [CNTW-1:0]           count,
    input  logic [sobm_pkg::PW-1:0]   prev_price,
    input  logic [sobm_pkg::SW-1:0]   prev_size,
    input  logic                      prev_above,
    input  logic [sobm_pkg::PW-1:0]   next_price,
    input  logic [sobm_pkg::SW-1:0]   next_size,
    input  logic [sobm_pkg::ACCW-1:0] prev_acc,
    output logic [sobm_pkg::PW-1:0]   price,
    output logic [sobm_pkg::SW-1:0]   size,
    output logic                      above,
    output logic                      eq,
    output logic [sobm_pkg::ACCW-1:0] acc
);

    localparam logic [CNTW-1:0] IDX_C = CNTW'(IDX);

    logic [sobm_pkg::PW-1:0]   price_reg, price_next;
    logic [sobm_pkg::SW-1:0]   size_reg, size_next;
    logic [sobm_pkg::ACCW-1:0] acc_reg, acc_next;
    logic                      occ;
    logic                      at_end;
    logic                      in_depth;

    assign occ      = IDX_C < count;
    assign at_end   = IDX_C == count;
    assign eq       = occ && (price_reg == cmd.price);
    assign above    = occ && (IS_ASK ? (cmd.price < price_reg) : (cmd.price > price_reg));
    assign in_depth = occ && (int'(cmd.depth) > IDX);

    // An upsert of a held price sets its size, else shifts the tail down by one behind
    // the insertion point; an erase pulls each cell from the match on up from the next.
    always_comb
    begin
        price_next = price_reg;
        size_next  = size_reg;
        case (cmd.kind)
            sobm_pkg::CMD_UPSERT:
            begin
                if (cmd.any_eq)
                begin
                    if (eq)
                    begin
                        size_next = cmd.size;
                    end
                end
                else if (prev_above)
                begin
                    price_next = prev_price;
                    size_next  = prev_size;
                end
                else if (above || at_end)
                begin
                    price_next = cmd.price;
                    size_next  = cmd.size;
                end
            end
            sobm_pkg::CMD_ERASE:
            begin
                if (cmd.any_eq && (eq || above))
                begin
                    price_next = next_price;
                    size_next  = next_size;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign acc_next = ((IDX == 0) ? '0 : prev_acc)
                    + (in_depth ? sobm_pkg::ACCW'(size_reg) : '0);

    always_ff @(posedge clk)
    begin
        price_reg <= price_next;
        size_reg  <= size_next;
        acc_reg   <= acc_next;
    end

    assign price = price_reg;
    assign size  = size_reg;
    assign acc   = acc_reg;

endmodule

@@ design/sobm_side.sv @@
`timescale 1ns / 1ps

module sobm_side #(
    parameter int LEVELS = sobm_pkg::LEVELS_DEF,
    parameter bit IS_ASK = 1'b0,
    parameter int CNTW   = $clog2(LEVELS + 1)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  sobm_pkg::side_cmd_t       cmd,
    output logic [CNTW-1:0]           count,
    output logic [sobm_pkg::PW-1:0]   best_price,
    output logic [sobm_pkg::ACCW-1:0] top_sum,
    output logic                      dropped
);

    localparam logic [CNTW-1:0] FULL = CNTW'(LEVELS);

    logic [sobm_pkg::PW-1:0]   price_w [LEVELS];
    logic [sobm_pkg::SW-1:0]   size_w  [LEVELS];
    logic [sobm_pkg::ACCW-1:0] acc_w   [LEVELS];
    logic [LEVELS-1:0]         above_w;
    logic [LEVELS-1:0]         eq_w;
    logic                      any_eq;
    sobm_pkg::cell_cmd_t       ccmd;
    logic [CNTW-1:0]           count_reg, count_next;

    assign any_eq = |eq_w;

    always_comb
    begin
        ccmd.kind   = cmd.kind;
        ccmd.price  = cmd.price;
        ccmd.size   = cmd.size;
        ccmd.depth  = cmd.depth;
        ccmd.any_eq = any_eq;
    end

    for (genvar g = 0; g < LEVELS; g++)
    begin : g_cell
        logic [sobm_pkg::PW-1:0]   pp, np;
        logic [sobm_pkg::SW-1:0]   ps, ns;
        logic                      pa;
        logic [sobm_pkg::ACCW-1:0] pacc;

        if (g == 0)
        begin : g_first
            assign pp   = '0;
            assign ps   = '0;
            assign pa   = 1'b0;
            assign pacc = '0;
        end
        else
        begin : g_mid
            assign pp   = price_w[g-1];
            assign ps   = size_w[g-1];
            assign pa   = above_w[g-1];
            assign pacc = acc_w[g-1];
        end

        if (g == LEVELS - 1)
        begin : g_last
            assign np = price_w[g];
            assign ns = size_w[g];
        end
        else
        begin : g_inner
            assign np = price_w[g+1];
            assign ns = size_w[g+1];
        end

        sobm_cell #(
            .IDX    (g),
            .IS_ASK (IS_ASK),
            .CNTW   (CNTW)
        ) u_cell (
            .clk        (clk),
            .cmd        (ccmd),
            .count      (count_reg),
            .prev_price (pp),
            .prev_size  (ps),
            .prev_above (pa),
            .next_price (np),
            .next_size  (ns),
            .prev_acc   (pacc),
            .price      (price_w[g]),
            .size       (size_w[g]),
            .above      (above_w[g]),
            .eq         (eq_w[g]),
            .acc        (acc_w[g])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        dropped    = 1'b0;
        case (cmd.kind)
            sobm_pkg::CMD_CLEAR:
            begin
                count_next = '0;
            end
            sobm_pkg::CMD_UPSERT:
            begin
                if (!any_eq)
                begin
                    if (count_reg == FULL)
                    begin
                        dropped = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            sobm_pkg::CMD_ERASE:
            begin
                if (any_eq)
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign count      = count_reg;
    assign best_price = price_w[0];
    assign top_sum    = acc_w[LEVELS-1];

endmodule

@@ design/sobm_div.sv @@
`timescale 1ns / 1ps

module sobm_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [sobm_pkg::ACCW-1:0]        bv,
    input  logic [sobm_pkg::ACCW-1:0]        av,
    output logic                             done,
    output logic signed [sobm_pkg::IMBW-1:0] imb
);

    localparam int RW = sobm_pkg::ACCW + 2;
    localparam int NSTEP = sobm_pkg::IMBW;
    localparam int STW = $clog2(NSTEP);
    localparam logic [STW-1:0] LAST = STW'(NSTEP - 1);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [STW-1:0]                  step_reg, step_next;
    logic [RW-1:0]                   r_reg, r_next;
    logic [sobm_pkg::ACCW:0]         tot_reg, tot_next;
    logic [sobm_pkg::IMBW-1:0]       q_reg, q_next;
    logic                            neg_reg, neg_next;
    logic                            bit_c;
    logic [RW-1:0]                   r_sub;

    assign bit_c = r_reg >= RW'(tot_reg);
    assign r_sub = bit_c ? (r_reg - RW'(tot_reg)) : r_reg;

    // Restoring long division of |B - A| * 2^15 by B + A, one quotient bit a cycle.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        r_next    = r_reg;
        tot_next  = tot_reg;
        q_next    = q_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            neg_next  = av > bv;
            r_next    = RW'((bv >= av) ? (bv - av) : (av - bv));
            tot_next  = (sobm_pkg::ACCW + 1)'(bv) + (sobm_pkg::ACCW + 1)'(av);
        end
        else if (busy_reg)
        begin
            q_next    = {q_reg[sobm_pkg::IMBW-2:0], bit_c};
            r_next    = {r_sub[RW-2:0], 1'b0};
            step_next = step_reg + 1'b1;
            if (step_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg   <= r_next;
        tot_reg <= tot_next;
        q_reg   <= q_next;
        neg_reg <= neg_next;
    end

    always_comb
    begin
        if (tot_reg == '0)
        begin
            imb = '0;
        end
        else if (neg_reg)
        begin
            imb = -$signed(q_reg);
        end
        else if (q_reg[sobm_pkg::IMBW-1])
        begin
            imb = {1'b0, {(sobm_pkg::IMBW - 1){1'b1}}};
        end
        else
        begin
            imb = $signed(q_reg);
        end
    end

    assign done = done_reg;

endmodule

@@ design/sequenced_order_book_maintainer_core.sv @@
`timescale 1ns / 1ps

// Channel  Handshake              Payload
// in       in_valid / in_ready    operation, side, price, size, first_id, final_id
// out      out_valid / out_ready  accepted .. level_dropped, one beat per in beat
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// After its in beat is taken, an item passes through these steps in order: it is
// applied to the cell rows, the depth sums ripple down the rows, the divider runs
// its sixteen quotient steps and flags completion, the out register is loaded, and
// the sequencer returns to idle, in which the next in beat is taken; no in beat is
// taken while an item is in progress.
// Reset clears counts, mode, ids and flags; the price tables hold no reset value.
// A stalled out beat holds in its register; the next in beat is still taken, and
// its result waits in the last state until the register frees.

module sequenced_order_book_maintainer_core #(
    parameter int LEVELS = sobm_pkg::LEVELS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [2:0]                         operation,
    input  logic                               side,
    input  logic [sobm_pkg::PW-1:0]            price,
    input  logic [sobm_pkg::SW-1:0]            size,
    input  logic [sobm_pkg::IDW-1:0]           first_id,
    input  logic [sobm_pkg::IDW-1:0]           final_id,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               accepted,
    output logic                               book_live,
    output logic                               book_ready,
    output logic                               book_stale,
    output logic [sobm_pkg::PW-1:0]            best_bid,
    output logic [sobm_pkg::PW-1:0]            best_ask,
    output logic [sobm_pkg::MIDW-1:0]          mid_half_ticks,
    output logic signed [sobm_pkg::IMBW-1:0]   imbalance,
    output logic [sobm_pkg::OUT_LW-1:0]        bid_levels,
    output logic [sobm_pkg::OUT_LW-1:0]        ask_levels,
    output logic                               level_dropped,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sobm_pkg::CFG_IW-1:0]        cfg_index,
    input  logic [sobm_pkg::CFG_DW-1:0]        cfg_data
);

    localparam int CNTW = $clog2(LEVELS + 1);
    localparam logic [CNTW-1:0] SUM_LAST = CNTW'(LEVELS);

    sobm_pkg::state_t state_reg, state_next;

    // Captured input beat.
    sobm_pkg::op_t                op_reg;
    logic                         side_reg;
    logic [sobm_pkg::PW-1:0]      price_reg;
    logic [sobm_pkg::SW-1:0]      size_reg;
    logic [sobm_pkg::IDW-1:0]     first_reg;
    logic [sobm_pkg::IDW-1:0]     final_reg;

    // Book control state.
    logic [sobm_pkg::IDW-1:0]     last_id_reg, last_id_next;
    logic [sobm_pkg::IDW-1:0]     pend_id_reg, pend_id_next;
    logic                         live_reg, live_next;
    sobm_pkg::mode_t              mode_reg, mode_next;
    logic [sobm_pkg::TKW-1:0]     ticks_reg, ticks_next;
    logic                         acc_flag_reg, acc_flag_next;
    logic                         drop_flag_reg, drop_flag_next;

    logic [sobm_pkg::TKW-1:0]     stale_lim_reg;
    logic [sobm_pkg::DEPW-1:0]    depth_reg;
    logic [sobm_pkg::DEPW-1:0]    depth_eff;

    logic [CNTW-1:0]              sum_cnt_reg, sum_cnt_next;

    // FSM outputs.
    logic                         apply_en;
    logic                         div_start;
    logic                         cap_en;

    // Side rows.
    sobm_pkg::side_cmd_t          bid_cmd, ask_cmd;
    logic [CNTW-1:0]              bid_cnt, ask_cnt;
    logic [sobm_pkg::PW-1:0]      bid_best, ask_best;
    logic [sobm_pkg::ACCW-1:0]    bid_sum, ask_sum;
    logic                         bid_drop, ask_drop;
    logic                         div_done;
    logic signed [sobm_pkg::IMBW-1:0] div_imb;

    // Output register.
    logic                         out_valid_reg, out_valid_next;
    logic                         o_acc_reg, o_live_reg, o_ready_reg, o_stale_reg, o_drop_reg;
    logic [sobm_pkg::PW-1:0]      o_bb_reg, o_ba_reg;
    logic [sobm_pkg::MIDW-1:0]    o_mid_reg;
    logic signed [sobm_pkg::IMBW-1:0] o_imb_reg;
    logic [sobm_pkg::OUT_LW-1:0]  o_bl_reg, o_al_reg;
    logic                         ready_c;

    assign depth_eff = (depth_reg == '0) ? sobm_pkg::DEPW'(1) : depth_reg;

    // ------------------------------------------------------------------
    // Sequencer: next state.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sobm_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sobm_pkg::ST_APPLY;
                end
            end
            sobm_pkg::ST_APPLY:
            begin
                state_next = sobm_pkg::ST_SUM;
            end
            sobm_pkg::ST_SUM:
            begin
                if (sum_cnt_reg == SUM_LAST)
                begin
                    state_next = sobm_pkg::ST_DIV;
                end
            end
            sobm_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = sobm_pkg::ST_DONE;
                end
            end
            sobm_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = sobm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sobm_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer: outputs.
    always_comb
    begin
        in_ready     = 1'b0;
        apply_en     = 1'b0;
        div_start    = 1'b0;
        cap_en       = 1'b0;
        sum_cnt_next = '0;
        case (state_reg)
            sobm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            sobm_pkg::ST_APPLY:
            begin
                apply_en = 1'b1;
            end
            sobm_pkg::ST_SUM:
            begin
                sum_cnt_next = sum_cnt_reg + 1'b1;
                div_start    = sum_cnt_reg == SUM_LAST;
            end
            sobm_pkg::ST_DONE:
            begin
                cap_en = !out_valid_reg || out_ready;
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Item decode: the book protocol applied to the captured beat.
    // ------------------------------------------------------------------
    function automatic sobm_pkg::side_cmd_t mk_cmd(sobm_pkg::cmd_kind_t kind,
                                                   logic [sobm_pkg::PW-1:0] p,
                                                   logic [sobm_pkg::SW-1:0] s,
                                                   logic [sobm_pkg::DEPW-1:0] d);
        sobm_pkg::side_cmd_t c;
        c.kind  = kind;
        c.price = p;
        c.size  = s;
        c.depth = d;
        return c;
    endfunction

    always_comb
    begin
        sobm_pkg::cmd_kind_t lvl_kind;
        sobm_pkg::cmd_kind_t both_kind;
        logic                crossed;

        lvl_kind       = sobm_pkg::CMD_NONE;
        both_kind      = sobm_pkg::CMD_NONE;
        last_id_next   = last_id_reg;
        pend_id_next   = pend_id_reg;
        live_next      = live_reg;
        mode_next      = mode_reg;
        ticks_next     = ticks_reg;
        acc_flag_next  = acc_flag_reg;
        crossed        = (bid_cnt != '0) && (ask_cnt != '0) && (bid_best >= ask_best);

        if (apply_en)
        begin
            acc_flag_next = 1'b0;
            case (op_reg)
                sobm_pkg::OP_RESET:
                begin
                    both_kind    = sobm_pkg::CMD_CLEAR;
                    last_id_next = '0;
                    live_next    = 1'b0;
                    mode_next    = sobm_pkg::MODE_IDLE;
                end
                sobm_pkg::OP_SNAP_BEGIN:
                begin
                    both_kind     = sobm_pkg::CMD_CLEAR;
                    live_next     = 1'b0;
                    pend_id_next  = final_reg;
                    mode_next     = sobm_pkg::MODE_SNAP;
                    acc_flag_next = 1'b1;
                end
                sobm_pkg::OP_SNAP_LEVEL:
                begin
                    if (mode_reg == sobm_pkg::MODE_SNAP)
                    begin
                        if (size_reg != '0)
                        begin
                            lvl_kind = sobm_pkg::CMD_UPSERT;
                        end
                        acc_flag_next = 1'b1;
                    end
                end
                sobm_pkg::OP_SNAP_END:
                begin
                    if (mode_reg == sobm_pkg::MODE_SNAP)
                    begin
                        last_id_next  = pend_id_reg;
                        live_next     = (bid_cnt != '0) && (ask_cnt != '0);
                        ticks_next    = '0;
                        mode_next     = sobm_pkg::MODE_IDLE;
                        acc_flag_next = 1'b1;
                    end
                end
                sobm_pkg::OP_UPD_BEGIN:
                begin
                    if (!live_reg)
                    begin
                        mode_next = sobm_pkg::MODE_IDLE;
                    end
                    else if (final_reg <= last_id_reg)
                    begin
                        mode_next     = sobm_pkg::MODE_SKIP;
                        acc_flag_next = 1'b1;
                    end
                    else if ((first_reg > last_id_reg) &&
                             ((first_reg - last_id_reg) > sobm_pkg::IDW'(1)))
                    begin
                        // Gap in the id sequence: back to rebuilding.
                        both_kind    = sobm_pkg::CMD_CLEAR;
                        last_id_next = '0;
                        live_next    = 1'b0;
                        mode_next    = sobm_pkg::MODE_IDLE;
                    end
                    else
                    begin
                        pend_id_next  = final_reg;
                        mode_next     = sobm_pkg::MODE_UPD;
                        acc_flag_next = 1'b1;
                    end
                end
                sobm_pkg::OP_UPD_LEVEL:
                begin
                    if (mode_reg == sobm_pkg::MODE_UPD)
                    begin
                        lvl_kind = (size_reg == '0) ? sobm_pkg::CMD_ERASE
                                                    : sobm_pkg::CMD_UPSERT;
                        acc_flag_next = 1'b1;
                    end
                    else if (mode_reg == sobm_pkg::MODE_SKIP)
                    begin
                        acc_flag_next = 1'b1;
                    end
                end
                sobm_pkg::OP_UPD_END:
                begin
                    if (mode_reg == sobm_pkg::MODE_UPD)
                    begin
                        if (crossed)
                        begin
                            both_kind    = sobm_pkg::CMD_CLEAR;
                            last_id_next = '0;
                            live_next    = 1'b0;
                        end
                        else
                        begin
                            last_id_next  = pend_id_reg;
                            ticks_next    = '0;
                            acc_flag_next = 1'b1;
                        end
                    end
                    else if (mode_reg == sobm_pkg::MODE_SKIP)
                    begin
                        acc_flag_next = 1'b1;
                    end
                    if ((mode_reg == sobm_pkg::MODE_UPD) || (mode_reg == sobm_pkg::MODE_SKIP))
                    begin
                        mode_next = sobm_pkg::MODE_IDLE;
                    end
                end
                sobm_pkg::OP_TICK:
                begin
                    if (ticks_reg != '1)
                    begin
                        ticks_next = ticks_reg + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        bid_cmd = mk_cmd(both_kind, price_reg, size_reg, depth_eff);
        ask_cmd = mk_cmd(both_kind, price_reg, size_reg, depth_eff);
        if (lvl_kind != sobm_pkg::CMD_NONE)
        begin
            if (side_reg)
            begin
                ask_cmd.kind = lvl_kind;
            end
            else
            begin
                bid_cmd.kind = lvl_kind;
            end
        end
    end

    assign drop_flag_next = apply_en ? (bid_drop || ask_drop) : drop_flag_reg;

    // ------------------------------------------------------------------
    // Cell rows, one per side, and the shared imbalance divider.
    // ------------------------------------------------------------------
    sobm_side #(
        .LEVELS (LEVELS),
        .IS_ASK (1'b0),
        .CNTW   (CNTW)
    ) u_bid (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (bid_cmd),
        .count      (bid_cnt),
        .best_price (bid_best),
        .top_sum    (bid_sum),
        .dropped    (bid_drop)
    );

    sobm_side #(
        .LEVELS (LEVELS),
        .IS_ASK (1'b1),
        .CNTW   (CNTW)
    ) u_ask (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (ask_cmd),
        .count      (ask_cnt),
        .best_price (ask_best),
        .top_sum    (ask_sum),
        .dropped    (ask_drop)
    );

    sobm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .bv    (bid_sum),
        .av    (ask_sum),
        .done  (div_done),
        .imb   (div_imb)
    );

    // The book is ready when live with both sides present, positive and uncrossed.
    assign ready_c = live_reg && (bid_cnt != '0) && (ask_cnt != '0) &&
                     (bid_best != '0) && (ask_best != '0) && (bid_best < ask_best);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cap_en)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sobm_pkg::ST_IDLE;
            last_id_reg   <= '0;
            pend_id_reg   <= '0;
            live_reg      <= 1'b0;
            mode_reg      <= sobm_pkg::MODE_IDLE;
            ticks_reg     <= '0;
            acc_flag_reg  <= 1'b0;
            drop_flag_reg <= 1'b0;
            sum_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            stale_lim_reg <= sobm_pkg::STALE_RST;
            depth_reg     <= sobm_pkg::DEPTH_RST;
        end
        else
        begin
            state_reg     <= state_next;
            last_id_reg   <= last_id_next;
            pend_id_reg   <= pend_id_next;
            live_reg      <= live_next;
            mode_reg      <= mode_next;
            ticks_reg     <= ticks_next;
            acc_flag_reg  <= acc_flag_next;
            drop_flag_reg <= drop_flag_next;
            sum_cnt_reg   <= sum_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                if (cfg_index == sobm_pkg::CFG_STALE)
                begin
                    stale_lim_reg <= cfg_data;
                end
                else if (cfg_index == sobm_pkg::CFG_DEPTH)
                begin
                    depth_reg <= cfg_data[sobm_pkg::DEPW-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg    <= sobm_pkg::op_t'(operation);
            side_reg  <= side;
            price_reg <= price;
            size_reg  <= size;
            first_reg <= first_id;
            final_reg <= final_id;
        end
        if (cap_en)
        begin
            o_acc_reg   <= acc_flag_reg;
            o_live_reg  <= live_reg;
            o_ready_reg <= ready_c;
            o_stale_reg <= ticks_reg > stale_lim_reg;
            o_bb_reg    <= ready_c ? bid_best : '0;
            o_ba_reg    <= ready_c ? ask_best : '0;
            o_mid_reg   <= ready_c ? (sobm_pkg::MIDW'(bid_best) + sobm_pkg::MIDW'(ask_best)) : '0;
            o_imb_reg   <= ready_c ? div_imb : '0;
            o_bl_reg    <= sobm_pkg::OUT_LW'(bid_cnt);
            o_al_reg    <= sobm_pkg::OUT_LW'(ask_cnt);
            o_drop_reg  <= drop_flag_reg;
        end
    end

    assign cfg_ready      = 1'b1;
    assign out_valid      = out_valid_reg;
    assign accepted       = o_acc_reg;
    assign book_live      = o_live_reg;
    assign book_ready     = o_ready_reg;
    assign book_stale     = o_stale_reg;
    assign best_bid       = o_bb_reg;
    assign best_ask       = o_ba_reg;
    assign mid_half_ticks = o_mid_reg;
    assign imbalance      = o_imb_reg;
    assign bid_levels     = o_bl_reg;
    assign ask_levels     = o_al_reg;
    assign level_dropped  = o_drop_reg;

endmodule
